@@ design/csm_pkg.sv @@
// Shared types, constants and saturating arithmetic for the C source character metrics block.
package csm_pkg;

   localparam int COUNTER_WIDTH = 32;
   localparam int LINE_WIDTH    = 16;
   localparam int OUT_WIDTH     = 32;
   localparam int CNT_NUM       = 7;
   localparam int CNT_IDX_W     = $clog2(CNT_NUM);

   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_STAR      = 8'h2A;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;

   localparam logic [CNT_IDX_W-1:0] K_CHAR   = CNT_IDX_W'(0);
   localparam logic [CNT_IDX_W-1:0] K_CCHAR  = CNT_IDX_W'(1);
   localparam logic [CNT_IDX_W-1:0] K_SPACE  = CNT_IDX_W'(2);
   localparam logic [CNT_IDX_W-1:0] K_LCOM   = CNT_IDX_W'(3);
   localparam logic [CNT_IDX_W-1:0] K_BCOM   = CNT_IDX_W'(4);
   localparam logic [CNT_IDX_W-1:0] K_LINE   = CNT_IDX_W'(5);
   localparam logic [CNT_IDX_W-1:0] K_STRING = CNT_IDX_W'(6);

   typedef logic [COUNTER_WIDTH-1:0] cnt_type;
   typedef logic [LINE_WIDTH-1:0]    line_type;

   localparam cnt_type CNT_MAX = '1;

   typedef enum logic [3:0] {
      ST_NORMAL   = 4'd0,
      ST_CHAR     = 4'd1,
      ST_STRING   = 4'd2,
      ST_CHR_BSL  = 4'd3,
      ST_STR_BSL  = 4'd4,
      ST_SLASH    = 4'd5,
      ST_LCOMMENT = 4'd6,
      ST_BCOMMENT = 4'd7,
      ST_BSTAR    = 4'd8
   } lex_state_type;

   typedef struct packed {
      logic [7:0] amount;
      logic       newline;
      logic       space;
      logic       lcom;
      logic       bcom;
      logic       str;
      logic       cchar_inc;
      logic       cchar_dec;
   } csm_evt_type;

   typedef struct packed {
      logic [OUT_WIDTH-1:0]  char_count;
      logic [OUT_WIDTH-1:0]  comment_char_count;
      logic [OUT_WIDTH-1:0]  space_count;
      logic [OUT_WIDTH-1:0]  line_comment_count;
      logic [OUT_WIDTH-1:0]  block_comment_count;
      logic [OUT_WIDTH-1:0]  line_count;
      logic [LINE_WIDTH-1:0] max_line_length;
      logic [OUT_WIDTH-1:0]  string_count;
   } csm_result_type;

   function automatic cnt_type sat_add(cnt_type c, logic [7:0] n);
      logic [COUNTER_WIDTH:0] sum;
      sum = (COUNTER_WIDTH+1)'(c) + (COUNTER_WIDTH+1)'(n);
      return sum[COUNTER_WIDTH] ? CNT_MAX : sum[COUNTER_WIDTH-1:0];
   endfunction

   function automatic line_type sat_line(line_type c, logic [7:0] n);
      logic [LINE_WIDTH:0] sum;
      sum = (LINE_WIDTH+1)'(c) + (LINE_WIDTH+1)'(n);
      return sum[LINE_WIDTH] ? '1 : sum[LINE_WIDTH-1:0];
   endfunction

   function automatic logic [OUT_WIDTH-1:0] to_out(cnt_type c);
      logic [63:0] wide;
      wide = 64'(c);
      return wide[OUT_WIDTH-1:0];
   endfunction

endpackage

@@ design/csm_front.sv @@
// Lexer front end: follows the lexical state and classifies each accepted item into an event.
module csm_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                command,
   input  logic [7:0]          ch,
   input  logic [7:0]          id_length,
   output csm_pkg::csm_evt_type evt
);

   csm_pkg::lex_state_type state_ff;
   csm_pkg::lex_state_type state_in;
   logic                   is_ws;

   assign is_ws = (ch == csm_pkg::CH_SPACE) ||
                  (ch inside {[csm_pkg::CH_TAB:csm_pkg::CH_CR]});

   always_comb begin
      state_in = state_ff;
      if (!command) begin
         case (state_ff)
            csm_pkg::ST_NORMAL: begin
               if (is_ws)                            state_in = csm_pkg::ST_NORMAL;
               else if (ch == csm_pkg::CH_SLASH)     state_in = csm_pkg::ST_SLASH;
               else if (ch == csm_pkg::CH_SQUOTE)    state_in = csm_pkg::ST_CHAR;
               else if (ch == csm_pkg::CH_DQUOTE)    state_in = csm_pkg::ST_STRING;
            end
            csm_pkg::ST_CHAR: begin
               if (ch == csm_pkg::CH_SQUOTE)         state_in = csm_pkg::ST_NORMAL;
               else if (ch == csm_pkg::CH_BACKSLASH) state_in = csm_pkg::ST_CHR_BSL;
            end
            csm_pkg::ST_STRING: begin
               if (ch == csm_pkg::CH_DQUOTE)         state_in = csm_pkg::ST_NORMAL;
               else if (ch == csm_pkg::CH_BACKSLASH) state_in = csm_pkg::ST_STR_BSL;
            end
            csm_pkg::ST_CHR_BSL: state_in = csm_pkg::ST_CHAR;
            csm_pkg::ST_STR_BSL: state_in = csm_pkg::ST_STRING;
            csm_pkg::ST_SLASH: begin
               if (ch == csm_pkg::CH_SLASH)          state_in = csm_pkg::ST_LCOMMENT;
               else if (ch == csm_pkg::CH_STAR)      state_in = csm_pkg::ST_BCOMMENT;
               else                                  state_in = csm_pkg::ST_NORMAL;
            end
            csm_pkg::ST_LCOMMENT: begin
               if (ch == csm_pkg::CH_NEWLINE)        state_in = csm_pkg::ST_NORMAL;
            end
            csm_pkg::ST_BCOMMENT: begin
               if (ch == csm_pkg::CH_STAR)           state_in = csm_pkg::ST_BSTAR;
            end
            csm_pkg::ST_BSTAR: begin
               if (ch == csm_pkg::CH_SLASH)          state_in = csm_pkg::ST_NORMAL;
               else if (ch != csm_pkg::CH_STAR)      state_in = csm_pkg::ST_BCOMMENT;
            end
            default: state_in = csm_pkg::ST_NORMAL;
         endcase
      end
   end

   always_comb begin
      evt         = '0;
      evt.amount  = command ? id_length : 8'd1;
      if (!command) begin
         evt.newline = (ch == csm_pkg::CH_NEWLINE);
         case (state_ff)
            csm_pkg::ST_NORMAL: begin
               evt.space = is_ws;
               evt.str   = !is_ws && (ch == csm_pkg::CH_DQUOTE);
            end
            csm_pkg::ST_SLASH: begin
               evt.lcom = (ch == csm_pkg::CH_SLASH);
               evt.bcom = (ch == csm_pkg::CH_STAR);
            end
            csm_pkg::ST_LCOMMENT: evt.cchar_inc = (ch != csm_pkg::CH_NEWLINE);
            csm_pkg::ST_BCOMMENT: evt.cchar_inc = 1'b1;
            csm_pkg::ST_BSTAR: begin
               evt.cchar_dec = (ch == csm_pkg::CH_SLASH);
               evt.cchar_inc = (ch != csm_pkg::CH_SLASH);
            end
            default: evt.cchar_inc = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csm_pkg::ST_NORMAL;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/csm_link_queue.sv @@
// Two-entry event queue between the lexer front end and the counting back end.
module csm_link_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  csm_pkg::csm_evt_type push_evt,
   output logic                 full,
   input  logic                 pop,
   output logic                 valid,
   output csm_pkg::csm_evt_type pop_evt
);

   csm_pkg::csm_evt_type mem_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;
   logic                 do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign valid   = (count_ff != 2'd0);
   assign pop_evt = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_evt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ design/csm_back.sv @@
// Counting back end: applies events to the saturating counters and queues the results.
module csm_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    evt_valid,
   input  csm_pkg::csm_evt_type    evt,
   output logic                    evt_pop,
   output logic                    result_empty,
   input  logic                    result_pop,
   output csm_pkg::csm_result_type result
);

   csm_pkg::cnt_type        cnt_ff [csm_pkg::CNT_NUM];
   csm_pkg::cnt_type        cnt_in [csm_pkg::CNT_NUM];
   csm_pkg::line_type       line_ff, line_in;
   csm_pkg::line_type       max_ff, max_in;
   csm_pkg::csm_result_type res_in;
   csm_pkg::csm_result_type mem_ff [2];
   logic                    wr_ptr_ff, rd_ptr_ff;
   logic [1:0]              count_ff, count_in;
   logic                    do_out_pop;

   assign do_out_pop   = result_pop && (count_ff != 2'd0);
   assign evt_pop      = evt_valid && ((count_ff != 2'd2) || do_out_pop);
   assign result_empty = (count_ff == 2'd0);
   assign result       = mem_ff[rd_ptr_ff];

   always_comb begin
      for (int i = 0; i < csm_pkg::CNT_NUM; i++) begin
         cnt_in[i] = cnt_ff[i];
      end
      cnt_in[csm_pkg::K_CHAR]   = csm_pkg::sat_add(cnt_ff[csm_pkg::K_CHAR], evt.amount);
      cnt_in[csm_pkg::K_SPACE]  = csm_pkg::sat_add(cnt_ff[csm_pkg::K_SPACE], 8'(evt.space));
      cnt_in[csm_pkg::K_LCOM]   = csm_pkg::sat_add(cnt_ff[csm_pkg::K_LCOM], 8'(evt.lcom));
      cnt_in[csm_pkg::K_BCOM]   = csm_pkg::sat_add(cnt_ff[csm_pkg::K_BCOM], 8'(evt.bcom));
      cnt_in[csm_pkg::K_LINE]   = csm_pkg::sat_add(cnt_ff[csm_pkg::K_LINE], 8'(evt.newline));
      cnt_in[csm_pkg::K_STRING] = csm_pkg::sat_add(cnt_ff[csm_pkg::K_STRING], 8'(evt.str));
      if (evt.cchar_dec) begin
         if ((cnt_ff[csm_pkg::K_CCHAR] != csm_pkg::CNT_MAX) &&
             (cnt_ff[csm_pkg::K_CCHAR] != '0)) begin
            cnt_in[csm_pkg::K_CCHAR] = cnt_ff[csm_pkg::K_CCHAR] - csm_pkg::cnt_type'(1);
         end
      end else begin
         cnt_in[csm_pkg::K_CCHAR] =
            csm_pkg::sat_add(cnt_ff[csm_pkg::K_CCHAR], 8'(evt.cchar_inc));
      end

      max_in  = max_ff;
      line_in = csm_pkg::sat_line(line_ff, evt.amount);
      if (evt.newline) begin
         line_in = '0;
         if (line_ff > max_ff) begin
            max_in = line_ff;
         end
      end

      res_in.char_count          = csm_pkg::to_out(cnt_in[csm_pkg::K_CHAR]);
      res_in.comment_char_count  = csm_pkg::to_out(cnt_in[csm_pkg::K_CCHAR]);
      res_in.space_count         = csm_pkg::to_out(cnt_in[csm_pkg::K_SPACE]);
      res_in.line_comment_count  = csm_pkg::to_out(cnt_in[csm_pkg::K_LCOM]);
      res_in.block_comment_count = csm_pkg::to_out(cnt_in[csm_pkg::K_BCOM]);
      res_in.line_count          = csm_pkg::to_out(cnt_in[csm_pkg::K_LINE]);
      res_in.max_line_length     = max_in;
      res_in.string_count        = csm_pkg::to_out(cnt_in[csm_pkg::K_STRING]);

      count_in = count_ff + 2'(evt_pop) - 2'(do_out_pop);
   end

   always_ff @(posedge clock) begin
      if (evt_pop) begin
         mem_ff[wr_ptr_ff] <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < csm_pkg::CNT_NUM; i++) begin
            cnt_ff[i] <= '0;
         end
         line_ff   <= '0;
         max_ff    <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (evt_pop) begin
            for (int i = 0; i < csm_pkg::CNT_NUM; i++) begin
               cnt_ff[i] <= cnt_in[i];
            end
            line_ff   <= line_in;
            max_ff    <= max_in;
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_out_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

endmodule

@@ design/c_source_char_metrics.sv @@
// Top level of the C source character metrics block.
// Each item's event is registered in the link queue and its result in the result queue.
// Throughput: one item per cycle while neither queue is full; the lexer state register in
// the front end and the counters in the back end each form a per-item loop.
// Reset: synchronous; clears the lexer to normal text, all counters, line lengths
// and both queues.
module c_source_char_metrics (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_command,
   input  logic [7:0]  req_ch,
   input  logic [7:0]  req_id_length,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_char_count,
   output logic [31:0] rsp_comment_char_count,
   output logic [31:0] rsp_space_count,
   output logic [31:0] rsp_line_comment_count,
   output logic [31:0] rsp_block_comment_count,
   output logic [31:0] rsp_line_count,
   output logic [15:0] rsp_max_line_length,
   output logic [31:0] rsp_string_count
);

   logic                    req_accept;
   csm_pkg::csm_evt_type    front_evt;
   csm_pkg::csm_evt_type    link_evt;
   logic                    link_valid;
   logic                    link_pop;
   csm_pkg::csm_result_type result;

   assign req_accept = req_push && !req_full;

   csm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .command   (req_command),
      .ch        (req_ch),
      .id_length (req_id_length),
      .evt       (front_evt)
   );

   csm_link_queue u_link (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .push_evt (front_evt),
      .full     (req_full),
      .pop      (link_pop),
      .valid    (link_valid),
      .pop_evt  (link_evt)
   );

   csm_back u_back (
      .clock        (clock),
      .reset        (reset),
      .evt_valid    (link_valid),
      .evt          (link_evt),
      .evt_pop      (link_pop),
      .result_empty (rsp_empty),
      .result_pop   (rsp_pop),
      .result       (result)
   );

   assign rsp_char_count          = result.char_count;
   assign rsp_comment_char_count  = result.comment_char_count;
   assign rsp_space_count         = result.space_count;
   assign rsp_line_comment_count  = result.line_comment_count;
   assign rsp_block_comment_count = result.block_comment_count;
   assign rsp_line_count          = result.line_count;
   assign rsp_max_line_length     = result.max_line_length;
   assign rsp_string_count        = result.string_count;

endmodule
